// File: design/fatlb_pkg.sv
`timescale 1ns / 1ps

package fatlb_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PAGE_LSB = 12;
  localparam int unsigned TAG_W    = ADDR_W - PAGE_LSB;
  localparam int unsigned LFSR_W   = 16;

  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hffff_f000;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef logic [1:0] op_t;

  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_FILL   = 2'd1;
  localparam op_t OP_FLUSH  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted request
    logic compare;      // register match vector, free vector and full flag
    logic encode;       // register hit, match index and free index
    logic lfsr_adv;     // advance the victim LFSR and start the remainder unit
    logic mod_step;     // one step of the remainder unit
    logic write_entry;  // write tag, frame and valid of the chosen slot
    logic flush;        // clear all valid bits
    logic read_frame;   // read the frame of the matching entry
    logic load_out;     // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic mod_last;
  } dp_sts_t;

endpackage

// File: design/fatlb_req_if.sv
`timescale 1ns / 1ps

interface fatlb_req_if import fatlb_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [ADDR_W-1:0]   addr;
  logic [ADDR_W-1:0]   phys_page;

  modport source (output valid, output op, output addr, output phys_page, input ready);
  modport sink   (input valid, input op, input addr, input phys_page, output ready);
endinterface

// File: design/fatlb_rsp_if.sv
`timescale 1ns / 1ps

interface fatlb_rsp_if import fatlb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [ADDR_W-1:0]   result_addr;

  modport source (output valid, output hit, output result_addr, input ready);
  modport sink   (input valid, input hit, input result_addr, output ready);
endinterface

// File: design/fatlb_dp.sv
`timescale 1ns / 1ps

module fatlb_dp import fatlb_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_t               op_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [ADDR_W-1:0] phys_page_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic              hit_o,
  output logic [ADDR_W-1:0] result_addr_o
);

  localparam int unsigned IdxW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned RecipShift = LFSR_W + IdxW;
  // ceil(2^RecipShift / ENTRIES): exact quotient for every 16-bit LFSR value
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
  localparam logic [LFSR_W-1:0] EntriesL = LFSR_W'(ENTRIES);

  // Request registers
  op_t               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TAG_W-1:0]  phys_q;

  // Entry state
  logic [ENTRIES-1:0] valid_q;
  logic [TAG_W-1:0]   tag_q [ENTRIES];
  logic [TAG_W-1:0]   frame_mem [ENTRIES];

  // Search state
  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] free_q;
  logic               full_q;
  logic               hit_q;
  logic [IdxW-1:0]    match_idx_q;
  logic [IdxW-1:0]    free_idx_q;
  logic [TAG_W-1:0]   frame_rd_q;

  // Victim selection
  logic [LFSR_W-1:0]        lfsr_q, lfsr_d;
  logic [IdxW-1:0]          rem_q, rem_d;
  logic [LFSR_W-1:0]        quot_q, quot_d;
  logic                     step_q;
  logic [LFSR_W+RecipW-1:0] quot_prod, quot_sh;
  logic [LFSR_W-1:0]        quot_mul, rem_full;

  // Result register
  logic              out_hit_q;
  logic [ADDR_W-1:0] out_addr_q;

  logic [TAG_W-1:0]   req_tag;
  logic [ENTRIES-1:0] match_vec;
  logic [IdxW-1:0]    match_idx, free_idx;
  logic [IdxW-1:0]    slot;

  assign req_tag = addr_q[ADDR_W-1:PAGE_LSB];

  // Compare the request tag against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (tag_q[i] == req_tag);
    end
  end

  // Pick the lowest set bit of the registered vectors
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IdxW'(i);
      end
      if (free_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  // Fibonacci LFSR, taps 16 14 13 11, shifting right
  assign lfsr_d = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

  // Remainder by reciprocal multiplication: quotient first, then subtract
  assign quot_prod = {{RecipW{1'b0}}, lfsr_q} * {{LFSR_W{1'b0}}, RecipMul};
  assign quot_sh   = quot_prod >> RecipShift;
  assign quot_d    = quot_sh[LFSR_W-1:0];
  assign quot_mul  = quot_q * EntriesL;
  assign rem_full  = lfsr_q - quot_mul;
  assign rem_d     = rem_full[IdxW-1:0];

  assign slot = full_q ? rem_q : free_idx_q;

  // Capture request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      addr_q <= addr_i;
      phys_q <= phys_page_i[ADDR_W-1:PAGE_LSB];
    end
  end

  // Valid bits: cleared by reset and flush, set by fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.flush) begin
      valid_q <= '0;
    end else if (cmd_i.write_entry) begin
      valid_q[slot] <= 1'b1;
    end
  end

  // Tag store, compared in parallel
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      tag_q[slot] <= req_tag;
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      frame_mem[slot] <= phys_q;
    end
    if (cmd_i.read_frame) begin
      frame_rd_q <= frame_mem[match_idx_q];
    end
  end

  // Search pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      match_q <= match_vec;
      free_q  <= ~valid_q;
      full_q  <= &valid_q;
    end
    if (cmd_i.encode) begin
      hit_q       <= |match_q;
      match_idx_q <= match_idx;
      free_idx_q  <= free_idx;
    end
  end

  // Victim LFSR and two-step remainder unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
      rem_q  <= '0;
      quot_q <= '0;
      step_q <= 1'b0;
    end else if (cmd_i.lfsr_adv) begin
      lfsr_q <= lfsr_d;
      step_q <= 1'b0;
    end else if (cmd_i.mod_step) begin
      if (!step_q) begin
        quot_q <= quot_d;
        step_q <= 1'b1;
      end else begin
        rem_q  <= rem_d;
        step_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q <= (op_q == OP_LOOKUP) && hit_q;
      if (op_q != OP_LOOKUP) begin
        out_addr_q <= '0;
      end else if (hit_q) begin
        out_addr_q <= {frame_rd_q, {PAGE_LSB{1'b0}}} & PAGE_MASK;
      end else begin
        out_addr_q <= addr_q;
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.full     = full_q;
  assign sts_o.mod_last = step_q;

  assign hit_o         = out_hit_q;
  assign result_addr_o = out_addr_q;

endmodule

// File: design/fatlb_ctrl.sv
`timescale 1ns / 1ps

module fatlb_ctrl import fatlb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_MOD,
    S_WR,
    S_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // The result register may be reloaded once its transfer is done
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    cmd_o       = '0;

    // Drop the result once it has been taken
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = S_ENC;
      end
      S_ENC: begin
        cmd_o.encode = 1'b1;
        case (sts_i.op)
          OP_LOOKUP: state_d = S_RD;
          OP_FILL: begin
            if (sts_i.full) begin
              cmd_o.lfsr_adv = 1'b1;
              state_d        = S_MOD;
            end else begin
              state_d = S_WR;
            end
          end
          OP_FLUSH: begin
            cmd_o.flush = 1'b1;
            state_d     = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.write_entry = 1'b1;
        state_d           = S_RESP;
      end
      S_RD: begin
        cmd_o.read_frame = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: design/fully_assoc_tlb_random_replace_unit.sv
`timescale 1ns / 1ps
// Each request is compared and encoded; then a lookup reads the frame, a fill with a free
// entry writes that entry, and a flush or unused op goes straight on to the result load.
// A fill into a full buffer takes a quotient step and a remainder step before its write;
// the victim index is a reciprocal-multiply remainder of the advanced LFSR.
// The result register lets the next request in while the last result waits.
// Reset clears all valid bits and seeds the LFSR with 0xACE1; no clearing pass.

module fully_assoc_tlb_random_replace_unit import fatlb_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fatlb_req_if.sink   req,
  fatlb_rsp_if.source rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fatlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fatlb_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (req.op),
    .addr_i        (req.addr),
    .phys_page_i   (req.phys_page),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (rsp.hit),
    .result_addr_o (rsp.result_addr)
  );

endmodule

// File: dv/fully_assoc_tlb_random_replace_unit_tb.sv
`timescale 1ns / 1ps

module fully_assoc_tlb_random_replace_unit_tb;
  import fatlb_pkg::*;

  localparam int unsigned NUM_ENTRIES = 64;
  localparam int unsigned CHUNK_REQS  = 380;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned MAX_CYCLES  = 600000;

  // The package names no code for the spare selector value
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] phys_page;
  } xlat_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] result_addr;
  } xlat_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  fatlb_req_if req_if ();
  fatlb_rsp_if rsp_if ();

  fully_assoc_tlb_random_replace_unit #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_if),
    .rsp   (rsp_if)
  );

  // Shadow copy of the translation buffer
  logic              tlb_valid [NUM_ENTRIES];
  logic [TAG_W-1:0]  tlb_tag   [NUM_ENTRIES];
  logic [TAG_W-1:0]  tlb_frame [NUM_ENTRIES];
  logic [LFSR_W-1:0] victim_sel;

  xlat_req_t        pending_reqs [$];
  xlat_rsp_t        expected_xlat [$];
  logic [TAG_W-1:0] known_tags [$];

  xlat_req_t   req_cur;
  logic        req_fire = 1'b0;
  int unsigned reqs_sent = 0;
  int unsigned reqs_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transfer to the shadow buffer and return the translation it yields
  function automatic xlat_rsp_t predict_translation(xlat_req_t r);
    xlat_rsp_t        res;
    logic [TAG_W-1:0] vpn;
    int               slot;
    int               i;
    res  = '0;
    vpn  = r.addr[ADDR_W-1:PAGE_LSB];
    slot = -1;
    case (r.op)
      OP_LOOKUP: begin
        res.result_addr = r.addr;
        // lowest matching entry wins when a tag sits in several entries
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (slot < 0 && tlb_valid[i] && tlb_tag[i] == vpn) slot = i;
        end
        if (slot >= 0) begin
          res.hit         = 1'b1;
          res.result_addr = {tlb_frame[slot], {PAGE_LSB{1'b0}}};
        end
      end
      OP_FILL: begin
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (slot < 0 && !tlb_valid[i]) slot = i;
        end
        // full buffer: step the LFSR once and take it modulo the depth
        if (slot < 0) begin
          victim_sel = {victim_sel[0] ^ victim_sel[2] ^ victim_sel[3] ^ victim_sel[5],
                        victim_sel[LFSR_W-1:1]};
          slot = int'(victim_sel % NUM_ENTRIES);
        end
        tlb_tag[slot]   = vpn;
        tlb_frame[slot] = r.phys_page[ADDR_W-1:PAGE_LSB];
        tlb_valid[slot] = 1'b1;
      end
      OP_FLUSH: begin
        for (i = 0; i < NUM_ENTRIES; i++) tlb_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_req(op_t op, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] phys);
    xlat_req_t r;
    r.op        = op;
    r.addr      = addr;
    r.phys_page = phys;
    pending_reqs.push_back(r);
  endtask

  // Episodes of fills, lookups and spare ops, flushes between; long ones can overflow
  task automatic gen_traffic(int unsigned n_reqs);
    int unsigned      made;
    int unsigned      span;
    int unsigned      k;
    int unsigned      kind;
    logic [TAG_W-1:0] vpn;
    logic [ADDR_W-1:0] addr;
    made = 0;
    while (made < n_reqs) begin
      span = ($urandom_range(1) == 1) ? $urandom_range(150, 260) : $urandom_range(20, 90);
      for (k = 0; k < span && made < n_reqs; k++) begin
        kind = $urandom_range(99);
        addr = $urandom;
        if (kind < 45) begin
          // mostly fresh tags, sometimes a tag already present
          if (known_tags.size() > 0 && $urandom_range(9) == 0)
            vpn = known_tags[$urandom_range(known_tags.size() - 1)];
          else
            vpn = addr[ADDR_W-1:PAGE_LSB];
          addr[ADDR_W-1:PAGE_LSB] = vpn;
          known_tags.push_back(vpn);
          push_req(OP_FILL, addr, $urandom);
        end else if (kind < 93) begin
          if (known_tags.size() > 0 && $urandom_range(3) != 0)
            addr[ADDR_W-1:PAGE_LSB] = known_tags[$urandom_range(known_tags.size() - 1)];
          push_req(OP_LOOKUP, addr, $urandom);
        end else if (kind < 96) begin
          push_req(OP_UNUSED, addr, $urandom);
        end else if (kind < 99) begin
          push_req(OP_LOOKUP, addr, $urandom);
        end else begin
          push_req(OP_FLUSH, addr, $urandom);
          known_tags.delete();
        end
        made++;
      end
      if (made < n_reqs) begin
        push_req(OP_FLUSH, $urandom, $urandom);
        known_tags.delete();
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || reqs_taken != reqs_sent || expected_xlat.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: hold the offered item until its transfer, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!(req_if.valid && !req_fire)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req_cur = pending_reqs.pop_front();
        reqs_sent++;
        req_if.valid     <= 1'b1;
        req_if.op        <= req_cur.op;
        req_if.addr      <= req_cur.addr;
        req_if.phys_page <= req_cur.phys_page;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every request transfer
  always @(posedge clk) begin
    req_fire <= rst_n && req_if.valid && req_if.ready;
    if (rst_n && req_if.valid && req_if.ready) begin
      expected_xlat.push_back(predict_translation(req_cur));
      reqs_taken++;
    end
  end

  // Response ready: random backpressure plus an occasional long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare each response transfer with the oldest prediction
  always @(posedge clk) begin : rsp_check
    xlat_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_xlat.size() == 0) begin
        $display("%0t: response with nothing outstanding, hit=%0b result_addr=%h",
                 $time, rsp_if.hit, rsp_if.result_addr);
        errors++;
      end else begin
        want = expected_xlat.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
          errors++;
        end
        if (rsp_if.result_addr !== want.result_addr) begin
          $display("%0t: result_addr expected %h actual %h",
                   $time, want.result_addr, rsp_if.result_addr);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned base;
    int          i;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_LOOKUP;
    req_if.addr      = '0;
    req_if.phys_page = '0;
    rsp_if.ready     = 1'b0;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_tag[i]   = '0;
      tlb_frame[i] = '0;
    end
    victim_sel = LFSR_SEED;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty buffer misses, field extremes, duplicate tags, spare selector, flush
    push_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
    push_req(OP_FILL,   32'hffff_ffff, 32'hffff_ffff);
    push_req(OP_LOOKUP, 32'hffff_f123, 32'h0000_0000);
    push_req(OP_FILL,   32'h0000_0abc, 32'h0000_0fff);
    push_req(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
    push_req(OP_FILL,   32'h1234_5000, 32'haaaa_a000);
    push_req(OP_FILL,   32'h1234_5fff, 32'h5555_5fff);
    push_req(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    push_req(OP_LOOKUP, 32'h1234_4fff, 32'h0000_0000);
    push_req(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    push_req(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    push_req(OP_FLUSH,  32'hffff_ffff, 32'hffff_ffff);
    push_req(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
    push_req(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    push_req(OP_FLUSH,  32'h0000_0000, 32'h0000_0000);

    // Sender idles more lightly than the receiver
    src_idle_pct = 32;
    snk_idle_pct = 52;
    gen_traffic(CHUNK_REQS);
    wait_drained();

    // Swap the idle rates
    src_idle_pct = 52;
    snk_idle_pct = 32;
    gen_traffic(CHUNK_REQS);
    wait_drained();

    // Full rate, with one long response hold while requests keep coming
    src_idle_pct = 0;
    snk_idle_pct = 0;
    base = reqs_taken;
    gen_traffic(CHUNK_REQS);
    while (reqs_taken < base + 60) @(posedge clk);
    hold_reqs++;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
